### hw/rtl/xmodem_sender_core_assert.svh
// Assertion macros used by the XMODEM sender core.
`ifndef XMODEM_SENDER_CORE_ASSERT_SVH
`define XMODEM_SENDER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define XMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define XMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/xms_pkg.sv
// Types, constants and helper functions of the XMODEM sender.
`default_nettype none

package xms_pkg;

  // Block and length geometry
  localparam int BLOCK_BYTES = 128;
  localparam int LEN_W       = 24;
  localparam int ACK_W       = LEN_W + 1;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int BUF_AW      = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(BLOCK_BYTES + 6);
  localparam int TIMER_W     = 16;
  localparam int TRY_W       = 5;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 16;

  // Line protocol bytes
  localparam logic [7:0] SOH_BYTE  = 8'h01;
  localparam logic [7:0] EOT_BYTE  = 8'h04;
  localparam logic [7:0] ACK_BYTE  = 8'h06;
  localparam logic [7:0] NAK_BYTE  = 8'h15;
  localparam logic [7:0] CAN_BYTE  = 8'h18;
  localparam logic [7:0] PAD_BYTE  = 8'h1A;
  localparam logic [7:0] SYNC_CRC  = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Input opcodes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_PAYLOAD = 3'd1;
  localparam logic [2:0] OP_LINE    = 3'd2;
  localparam logic [2:0] OP_READY   = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  // Final status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CANCELLED = 3'd1;
  localparam logic [2:0] ST_NO_SYNC   = 3'd2;
  localparam logic [2:0] ST_TX_ERROR  = 3'd3;
  localparam logic [2:0] ST_NO_EOT    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_LONG_WAIT   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_SHORT_WAIT  = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SYNC_TRIES  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_PKT_TRIES   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_EOT_TRIES   = 3'd4;

  // Configuration reset values
  localparam logic [TIMER_W-1:0] RST_LONG_WAIT  = 16'd400;
  localparam logic [TIMER_W-1:0] RST_SHORT_WAIT = 16'd200;
  localparam logic [TRY_W-1:0]   RST_SYNC_TRIES = 5'd16;
  localparam logic [TRY_W-1:0]   RST_PKT_TRIES  = 5'd25;
  localparam logic [TRY_W-1:0]   RST_EOT_TRIES  = 5'd10;

  // Transfer phases, one-hot
  typedef enum logic [11:0] {
    PH_IDLE      = 12'b0000_0000_0001,
    PH_SYNC_WAIT = 12'b0000_0000_0010,
    PH_SYNC_CAN  = 12'b0000_0000_0100,
    PH_LOAD      = 12'b0000_0000_1000,
    PH_SEND      = 12'b0000_0001_0000,
    PH_RESP_WAIT = 12'b0000_0010_0000,
    PH_RESP_CAN  = 12'b0000_0100_0000,
    PH_EOT_SEND  = 12'b0000_1000_0000,
    PH_EOT_WAIT  = 12'b0001_0000_0000,
    PH_ACK_SEND  = 12'b0010_0000_0000,
    PH_CANCEL    = 12'b0100_0000_0000,
    PH_DONE      = 12'b1000_0000_0000
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [2:0]       op;
    logic [LEN_W-1:0] total_length;
    logic [7:0]       payload_byte;
    logic [7:0]       line_byte;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             payload_request;
    logic [7:0]       payload_count;
    logic             done_res;
    logic [2:0]       status;
    logic [ACK_W-1:0] sent_length;
  } out_item_t;

  // Block buffer write port
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  // Source bytes of the current block: remaining length capped at one block
  function automatic logic [CNT_W-1:0] block_count(input logic [ACK_W-1:0] acked,
                                                   input logic [LEN_W-1:0] total);
    logic [ACK_W-1:0] tot;
    logic [ACK_W-1:0] rem;
    tot = {1'b0, total};
    rem = tot - acked;
    if (acked >= tot) return '0;
    if (rem > ACK_W'(BLOCK_BYTES)) return CNT_W'(BLOCK_BYTES);
    return rem[CNT_W-1:0];
  endfunction

  // One data byte into the check: CRC-16/XMODEM or 8-bit sum
  function automatic logic [15:0] check_next(input logic crc, input logic [15:0] chk,
                                             input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  s;
    s = chk[7:0] + b;
    c = chk ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return crc ? c : {8'h00, s};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/xms_block_buf.sv
// Block payload buffer: one write port, one registered read port.
`default_nettype none

module xms_block_buf (
  input  wire logic                       clk_i,
  input  wire xms_pkg::buf_wr_t           wr_i,
  input  wire logic [xms_pkg::BUF_AW-1:0] rd_addr_i,
  output logic [7:0]                      rd_data_o
);

  logic [7:0] mem_q [xms_pkg::BLOCK_BYTES];

  // Write while loading
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Registered read, address runs one byte ahead of the frame
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/xmodem_sender_core.sv
// Top level of the XMODEM sender: control, configuration and result register.
//
//   port group       direction  handshake              payload
//   in_*             in         in_valid_i/in_stall_o   xms_pkg::in_item_t
//   out_*            out        out_valid_o/out_stall_i xms_pkg::out_item_t
//   cfg_*            in         cfg_we_i                cfg_index_i, cfg_data_i
//
// Each input beat is worked in the cycle it is taken; its single result beat sits
// in the result register from the next cycle on, one beat per cycle while the output side does not stall.
// The frame byte path (buffer read, CRC byte update) sets the cycle time.
// Reset returns to idle with default timeouts and tries; no clearing pass.
// Input is stalled only while a result waits and the output side stalls.
`default_nettype none

module xmodem_sender_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire xms_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output xms_pkg::out_item_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [xms_pkg::CFG_AW-1:0] cfg_index_i,
  input  wire logic [xms_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int IDX_W = xms_pkg::IDX_W;
  localparam logic [IDX_W-1:0] IDX_NUM    = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_NUMINV = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_DATA0  = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_CHK_HI = IDX_W'(xms_pkg::BLOCK_BYTES + 3);
  localparam logic [IDX_W-1:0] IDX_FLEN   = IDX_W'(xms_pkg::BLOCK_BYTES + 4);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(xms_pkg::BLOCK_BYTES + 5);

  // Configuration registers
  logic [xms_pkg::TIMER_W-1:0] long_wait_q, short_wait_q;
  logic [xms_pkg::TRY_W-1:0]   sync_tries_q, pkt_tries_q, eot_tries_q;

  // Transfer state
  xms_pkg::phase_e             phase_q, phase_d;
  logic [7:0]                  pkt_num_q, pkt_num_d;
  logic [xms_pkg::ACK_W-1:0]   acked_q, acked_d;
  logic [xms_pkg::LEN_W-1:0]   total_q, total_d;
  logic [xms_pkg::TRY_W-1:0]   try_q, try_d;
  logic [xms_pkg::TIMER_W-1:0] wait_q, wait_d;
  logic                        crc_q, crc_d;
  logic [15:0]                 check_q, check_d;
  logic [IDX_W-1:0]            byte_index_q, byte_index_d;
  logic [xms_pkg::CNT_W-1:0]   loaded_q, loaded_d;
  logic [1:0]                  pend_q, pend_d;
  logic [2:0]                  status_q, status_d;

  // Result register
  logic                        out_valid_q;
  xms_pkg::out_item_t          res_q, res_d;

  logic                        in_acc;
  logic                        start_ok, ack_blk;
  logic [xms_pkg::CNT_W-1:0]   cnt_d;
  logic [xms_pkg::TRY_W-1:0]   try_inc;
  logic [xms_pkg::TIMER_W-1:0] wait_inc, limit;
  logic [IDX_W-1:0]            data_pos, idx_inc, rd_pos;
  logic [7:0]                  buf_rd_data;
  logic [7:0]                  data_byte, frm_byte;
  logic [15:0]                 frm_check;
  logic                        tx_valid;
  logic [7:0]                  tx_byte;
  xms_pkg::buf_wr_t            buf_wr;

  // Handshake: a waiting result only blocks input when it is itself stalled
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_wait_q  <= xms_pkg::RST_LONG_WAIT;
      short_wait_q <= xms_pkg::RST_SHORT_WAIT;
      sync_tries_q <= xms_pkg::RST_SYNC_TRIES;
      pkt_tries_q  <= xms_pkg::RST_PKT_TRIES;
      eot_tries_q  <= xms_pkg::RST_EOT_TRIES;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        xms_pkg::CFG_LONG_WAIT:  long_wait_q  <= cfg_data_i;
        xms_pkg::CFG_SHORT_WAIT: short_wait_q <= cfg_data_i;
        xms_pkg::CFG_SYNC_TRIES: sync_tries_q <= cfg_data_i[xms_pkg::TRY_W-1:0];
        xms_pkg::CFG_PKT_TRIES:  pkt_tries_q  <= cfg_data_i[xms_pkg::TRY_W-1:0];
        xms_pkg::CFG_EOT_TRIES:  eot_tries_q  <= cfg_data_i[xms_pkg::TRY_W-1:0];
        default: ;
      endcase
    end
  end

  // Acknowledged length and block size after this beat
  assign start_ok = (in_data_i.op == xms_pkg::OP_START) &&
                    (phase_q inside {xms_pkg::PH_IDLE, xms_pkg::PH_DONE});
  assign ack_blk  = (in_data_i.op == xms_pkg::OP_LINE) && (phase_q == xms_pkg::PH_RESP_WAIT) &&
                    (in_data_i.line_byte == xms_pkg::ACK_BYTE);

  always_comb begin
    acked_d = acked_q;
    total_d = total_q;
    if (in_acc && start_ok) begin
      acked_d = '0;
      total_d = in_data_i.total_length;
    end else if (in_acc && ack_blk) begin
      acked_d = acked_q + xms_pkg::ACK_W'(xms_pkg::BLOCK_BYTES);
    end
  end

  assign cnt_d = xms_pkg::block_count(acked_d, total_d);

  // Retry and timeout helpers
  assign try_inc  = try_q + xms_pkg::TRY_W'(1);
  assign wait_inc = (wait_q != '1) ? wait_q + xms_pkg::TIMER_W'(1) : wait_q;
  assign limit    = (phase_q inside {xms_pkg::PH_SYNC_WAIT, xms_pkg::PH_EOT_WAIT}) ?
                    long_wait_q : short_wait_q;

  // Frame byte at the current index
  assign data_pos  = byte_index_q - IDX_DATA0;
  assign idx_inc   = byte_index_q + IDX_W'(1);
  assign data_byte = (data_pos < IDX_W'(loaded_q))  ? buf_rd_data :
                     (data_pos == IDX_W'(loaded_q)) ? xms_pkg::PAD_BYTE : 8'h00;

  always_comb begin
    frm_check = check_q;
    if (byte_index_q == '0) begin
      frm_byte  = xms_pkg::SOH_BYTE;
      frm_check = '0;
    end else if (byte_index_q == IDX_NUM) begin
      frm_byte = pkt_num_q;
    end else if (byte_index_q == IDX_NUMINV) begin
      frm_byte = ~pkt_num_q;
    end else if (byte_index_q < IDX_CHK_HI) begin
      frm_byte  = data_byte;
      frm_check = xms_pkg::check_next(crc_q, check_q, data_byte);
    end else if (crc_q && (byte_index_q == IDX_CHK_HI)) begin
      frm_byte = check_q[15:8];
    end else begin
      frm_byte = check_q[7:0];
    end
  end

  // Phase step for one accepted beat
  always_comb begin
    logic sync_retry;
    logic pkt_retry;
    logic eot_retry;
    sync_retry   = 1'b0;
    pkt_retry    = 1'b0;
    eot_retry    = 1'b0;
    phase_d      = phase_q;
    pkt_num_d    = pkt_num_q;
    try_d        = try_q;
    wait_d       = wait_q;
    crc_d        = crc_q;
    check_d      = check_q;
    byte_index_d = byte_index_q;
    loaded_d     = loaded_q;
    pend_d       = pend_q;
    status_d     = status_q;
    tx_valid     = 1'b0;
    tx_byte      = 8'h00;
    buf_wr.en    = 1'b0;
    buf_wr.addr  = loaded_q[xms_pkg::BUF_AW-1:0];
    buf_wr.data  = in_data_i.payload_byte;

    if (in_acc) begin
      case (in_data_i.op)
        xms_pkg::OP_START: begin
          if (start_ok) begin
            pkt_num_d = 8'd1;
            try_d     = '0;
            wait_d    = '0;
            crc_d     = 1'b0;
            status_d  = xms_pkg::ST_OK;
            phase_d   = xms_pkg::PH_SYNC_WAIT;
          end
        end
        xms_pkg::OP_PAYLOAD: begin
          if (phase_q == xms_pkg::PH_LOAD) begin
            if ((loaded_q < cnt_d) && (loaded_q < xms_pkg::CNT_W'(xms_pkg::BLOCK_BYTES))) begin
              buf_wr.en = 1'b1;
              loaded_d  = loaded_q + xms_pkg::CNT_W'(1);
            end
            if (loaded_d >= cnt_d) begin
              phase_d      = xms_pkg::PH_SEND;
              byte_index_d = '0;
            end
          end
        end
        xms_pkg::OP_LINE: begin
          case (phase_q)
            xms_pkg::PH_SYNC_WAIT: begin
              if ((in_data_i.line_byte == xms_pkg::SYNC_CRC) ||
                  (in_data_i.line_byte == xms_pkg::NAK_BYTE)) begin
                crc_d        = (in_data_i.line_byte == xms_pkg::SYNC_CRC);
                try_d        = '0;
                wait_d       = '0;
                loaded_d     = '0;
                byte_index_d = '0;
                phase_d      = (cnt_d == '0) ? xms_pkg::PH_EOT_SEND : xms_pkg::PH_LOAD;
              end else if (in_data_i.line_byte == xms_pkg::CAN_BYTE) begin
                wait_d  = '0;
                phase_d = xms_pkg::PH_SYNC_CAN;
              end else begin
                sync_retry = 1'b1;
              end
            end
            xms_pkg::PH_SYNC_CAN: begin
              if (in_data_i.line_byte == xms_pkg::CAN_BYTE) phase_d = xms_pkg::PH_ACK_SEND;
              else sync_retry = 1'b1;
            end
            xms_pkg::PH_RESP_WAIT: begin
              if (ack_blk) begin
                pkt_num_d    = pkt_num_q + 8'd1;
                try_d        = '0;
                wait_d       = '0;
                loaded_d     = '0;
                byte_index_d = '0;
                phase_d      = (cnt_d == '0) ? xms_pkg::PH_EOT_SEND : xms_pkg::PH_LOAD;
              end else if (in_data_i.line_byte == xms_pkg::CAN_BYTE) begin
                wait_d  = '0;
                phase_d = xms_pkg::PH_RESP_CAN;
              end else begin
                pkt_retry = 1'b1;
              end
            end
            xms_pkg::PH_RESP_CAN: begin
              if (in_data_i.line_byte == xms_pkg::CAN_BYTE) phase_d = xms_pkg::PH_ACK_SEND;
              else pkt_retry = 1'b1;
            end
            xms_pkg::PH_EOT_WAIT: begin
              if (in_data_i.line_byte == xms_pkg::ACK_BYTE) begin
                status_d = xms_pkg::ST_OK;
                phase_d  = xms_pkg::PH_DONE;
              end else begin
                eot_retry = 1'b1;
              end
            end
            default: ;
          endcase
        end
        xms_pkg::OP_READY: begin
          case (phase_q)
            xms_pkg::PH_SEND: begin
              tx_valid     = 1'b1;
              tx_byte      = frm_byte;
              check_d      = frm_check;
              byte_index_d = idx_inc;
              if (idx_inc >= (crc_q ? IDX_LAST : IDX_FLEN)) begin
                wait_d  = '0;
                phase_d = xms_pkg::PH_RESP_WAIT;
              end
            end
            xms_pkg::PH_EOT_SEND: begin
              tx_valid = 1'b1;
              tx_byte  = xms_pkg::EOT_BYTE;
              wait_d   = '0;
              phase_d  = xms_pkg::PH_EOT_WAIT;
            end
            xms_pkg::PH_ACK_SEND: begin
              tx_valid = 1'b1;
              tx_byte  = xms_pkg::ACK_BYTE;
              status_d = xms_pkg::ST_CANCELLED;
              phase_d  = xms_pkg::PH_DONE;
            end
            xms_pkg::PH_CANCEL: begin
              tx_valid = 1'b1;
              tx_byte  = xms_pkg::CAN_BYTE;
              if (pend_q != 2'd0) pend_d = pend_q - 2'd1;
              if (pend_d == 2'd0) phase_d = xms_pkg::PH_DONE;
            end
            default: ;
          endcase
        end
        xms_pkg::OP_TICK: begin
          if (phase_q inside {xms_pkg::PH_SYNC_WAIT, xms_pkg::PH_EOT_WAIT,
                              xms_pkg::PH_SYNC_CAN, xms_pkg::PH_RESP_WAIT,
                              xms_pkg::PH_RESP_CAN}) begin
            wait_d = wait_inc;
            if (wait_inc >= limit) begin
              if (phase_q inside {xms_pkg::PH_SYNC_WAIT, xms_pkg::PH_SYNC_CAN}) begin
                sync_retry = 1'b1;
              end else if (phase_q == xms_pkg::PH_EOT_WAIT) begin
                eot_retry = 1'b1;
              end else begin
                pkt_retry = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end

    // Failed attempt: count it and either wait or send again, or give up
    if (sync_retry || pkt_retry || eot_retry) begin
      try_d  = try_inc;
      wait_d = '0;
    end
    if (sync_retry) begin
      if (try_inc >= sync_tries_q) begin
        status_d = xms_pkg::ST_NO_SYNC;
        pend_d   = 2'd3;
        phase_d  = xms_pkg::PH_CANCEL;
      end else begin
        phase_d = xms_pkg::PH_SYNC_WAIT;
      end
    end
    if (pkt_retry) begin
      if (try_inc >= pkt_tries_q) begin
        status_d = xms_pkg::ST_TX_ERROR;
        pend_d   = 2'd3;
        phase_d  = xms_pkg::PH_CANCEL;
      end else begin
        phase_d      = xms_pkg::PH_SEND;
        byte_index_d = '0;
      end
    end
    if (eot_retry) begin
      if (try_inc >= eot_tries_q) begin
        status_d = xms_pkg::ST_NO_EOT;
        phase_d  = xms_pkg::PH_DONE;
      end else begin
        phase_d = xms_pkg::PH_EOT_SEND;
      end
    end
  end

  // Result beat
  always_comb begin
    res_d.tx_valid        = tx_valid;
    res_d.tx_byte         = tx_byte;
    res_d.payload_request = (phase_d == xms_pkg::PH_LOAD);
    res_d.payload_count   = (phase_d == xms_pkg::PH_LOAD) ? cnt_d : '0;
    res_d.done_res        = (phase_d == xms_pkg::PH_DONE);
    res_d.status          = (phase_d == xms_pkg::PH_DONE) ? status_d : xms_pkg::ST_OK;
    res_d.sent_length     = acked_d;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= xms_pkg::PH_IDLE;
      pkt_num_q    <= 8'd1;
      acked_q      <= '0;
      total_q      <= '0;
      try_q        <= '0;
      wait_q       <= '0;
      crc_q        <= 1'b0;
      check_q      <= '0;
      byte_index_q <= '0;
      loaded_q     <= '0;
      pend_q       <= '0;
      status_q     <= xms_pkg::ST_OK;
    end else begin
      phase_q      <= phase_d;
      pkt_num_q    <= pkt_num_d;
      acked_q      <= acked_d;
      total_q      <= total_d;
      try_q        <= try_d;
      wait_q       <= wait_d;
      crc_q        <= crc_d;
      check_q      <= check_d;
      byte_index_q <= byte_index_d;
      loaded_q     <= loaded_d;
      pend_q       <= pend_d;
      status_q     <= status_d;
    end
  end

  // Result register: loads on every taken beat, empties when taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  // Buffer read address follows the next frame index
  assign rd_pos = byte_index_d - IDX_DATA0;

  xms_block_buf u_block_buf (
    .clk_i     (clk_i),
    .wr_i      (buf_wr),
    .rd_addr_i (rd_pos[xms_pkg::BUF_AW-1:0]),
    .rd_data_o (buf_rd_data)
  );

  // Checks
  `include "xmodem_sender_core_assert.svh"

  `XMS_ASSERT_IMP(a_stall_blocks_input, out_valid_q && out_stall_i, in_stall_o, "input taken over a stalled result")
  `XMS_ASSERT_NXT(a_tx_only_on_ready, in_acc && (in_data_i.op != xms_pkg::OP_READY), !res_q.tx_valid, "line byte without line ready")
  `XMS_ASSERT_IMP(a_cancels_in_cancel, phase_q != xms_pkg::PH_CANCEL, pend_q == 2'd0, "cancel count left outside cancel")
  `XMS_ASSERT_IMP(a_index_bound, 1'b1, byte_index_q <= IDX_LAST, "frame index past the frame")
  `XMS_ASSERT_IMP(a_load_bound, phase_q == xms_pkg::PH_LOAD, loaded_q < xms_pkg::CNT_W'(xms_pkg::BLOCK_BYTES), "load count overran the block")

endmodule

`default_nettype wire

### tb/sv/xmodem_sender_core_test.sv
// Self-checking testbench for the XMODEM sender core: directed table, then protocol-aware random.
module xmodem_sender_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xms_pkg::*;

  localparam logic [2:0] OP_SPARE = 3'd5;   // opcodes 5..7 mean nothing
  localparam int PASSES          = 6;
  localparam int LIVE_PER_PASS   = 95;
  localparam int HANG_CYCLES     = 5000;
  localparam int SCRIPT_LEN      = 23;
  localparam out_item_t NO_RES   = '0;

  // One row of the directed table
  typedef struct packed {
    logic [2:0]       op;
    logic [LEN_W-1:0] len;
    logic [7:0]       pb;
    logic [7:0]       lb;
    logic             fixed;
    out_item_t        res;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CFG_AW-1:0]   cfg_index_i = CFG_LONG_WAIT;
  logic [CFG_DW-1:0]   cfg_data_i = '0;

  xmodem_sender_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sender model: limits, transfer state and the block store
  logic [TIMER_W-1:0] long_lim, short_lim;
  logic [TRY_W-1:0]   sync_lim, pkt_lim, eot_lim;
  phase_e             ph;
  logic [7:0]         blk_num;
  logic [ACK_W-1:0]   acked;
  logic [LEN_W-1:0]   total;
  logic [TRY_W-1:0]   tries;
  logic [TIMER_W-1:0] timer;
  logic               crc_on;
  logic [15:0]        chk;
  logic [7:0]         blk_buf [BLOCK_BYTES];
  logic [7:0]         idx;
  logic [7:0]         loaded;
  logic [1:0]         cancels_left;
  logic [2:0]         fin_status;
  logic               beat_live;   // last beat was not ignored

  out_item_t awaited_results [$];
  int        fault_count = 0;
  int        in_idle_pct = 0;
  int        out_stall_pct = 0;
  int        quiet_left = 0;

  script_row_t script [SCRIPT_LEN] = '{
    '{OP_TICK,    24'd0,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_SPARE,   24'd0,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_PAYLOAD, 24'd0,        8'hFF, 8'h00,    1'b1, NO_RES},
    '{OP_START,   24'hFFFFFF,   8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_START,   24'd0,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_LINE,    24'd0,        8'h00, CAN_BYTE, 1'b1, NO_RES},
    '{OP_LINE,    24'd0,        8'h00, CAN_BYTE, 1'b1, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b1,
      '{1'b1, ACK_BYTE, 1'b0, 8'd0, 1'b1, ST_CANCELLED, 25'd0}},
    '{OP_START,   24'd0,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_LINE,    24'd0,        8'h00, 8'hFF,    1'b1, NO_RES},
    '{OP_LINE,    24'd0,        8'h00, NAK_BYTE, 1'b1, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b1,
      '{1'b1, EOT_BYTE, 1'b0, 8'd0, 1'b0, ST_OK, 25'd0}},
    '{OP_LINE,    24'd0,        8'h00, NAK_BYTE, 1'b1, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b1,
      '{1'b1, EOT_BYTE, 1'b0, 8'd0, 1'b0, ST_OK, 25'd0}},
    '{OP_LINE,    24'd0,        8'h00, ACK_BYTE, 1'b1,
      '{1'b0, 8'h00, 1'b0, 8'd0, 1'b1, ST_OK, 25'd0}},
    '{OP_START,   24'd1,        8'h00, 8'h00,    1'b1, NO_RES},
    '{OP_LINE,    24'd0,        8'h00, SYNC_CRC, 1'b1,
      '{1'b0, 8'h00, 1'b1, 8'd1, 1'b0, ST_OK, 25'd0}},
    '{OP_PAYLOAD, 24'd0,        8'h00, 8'h00,    1'b0, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b1,
      '{1'b1, SOH_BYTE, 1'b0, 8'd0, 1'b0, ST_OK, 25'd0}},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b0, NO_RES},
    '{OP_READY,   24'd0,        8'h00, 8'h00,    1'b0, NO_RES},
    '{OP_TICK,    24'd0,        8'h00, 8'h00,    1'b0, NO_RES}
  };

  function automatic void model_reset();
    long_lim     = RST_LONG_WAIT;
    short_lim    = RST_SHORT_WAIT;
    sync_lim     = RST_SYNC_TRIES;
    pkt_lim      = RST_PKT_TRIES;
    eot_lim      = RST_EOT_TRIES;
    ph           = PH_IDLE;
    blk_num      = 8'd1;
    acked        = '0;
    total        = '0;
    tries        = '0;
    timer        = '0;
    crc_on       = 1'b0;
    chk          = '0;
    idx          = '0;
    loaded       = '0;
    cancels_left = '0;
    fin_status   = ST_OK;
  endfunction

  // Source bytes still owed for this block, capped at one block
  function automatic logic [7:0] chunk_len();
    logic [ACK_W-1:0] left;
    if (acked >= {1'b0, total}) return 8'd0;
    left = {1'b0, total} - acked;
    if (left > ACK_W'(BLOCK_BYTES)) return 8'(BLOCK_BYTES);
    return left[7:0];
  endfunction

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {d, 8'h00};
    repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic void open_block();
    tries  = '0;
    timer  = '0;
    loaded = '0;
    idx    = '0;
    ph     = (chunk_len() == 8'd0) ? PH_EOT_SEND : PH_LOAD;
  endfunction

  function automatic void give_up(input logic [2:0] st);
    fin_status   = st;
    cancels_left = 2'd3;
    ph           = PH_CANCEL;
  endfunction

  function automatic void sync_again();
    tries = tries + 5'd1;
    timer = '0;
    if (tries >= sync_lim) give_up(ST_NO_SYNC);
    else ph = PH_SYNC_WAIT;
  endfunction

  function automatic void resend_block();
    tries = tries + 5'd1;
    timer = '0;
    if (tries >= pkt_lim) begin
      give_up(ST_TX_ERROR);
    end else begin
      ph  = PH_SEND;
      idx = '0;
    end
  endfunction

  function automatic void eot_again();
    tries = tries + 5'd1;
    timer = '0;
    if (tries >= eot_lim) begin
      fin_status = ST_NO_EOT;
      ph         = PH_DONE;
    end else begin
      ph = PH_EOT_SEND;
    end
  endfunction

  // Frame byte at idx: header, padded data, then the check
  function automatic logic [7:0] frame_byte();
    logic [7:0] pos;
    logic [7:0] d;
    pos = idx - 8'd3;
    if (idx == 8'd0) begin
      chk = '0;
      return SOH_BYTE;
    end
    if (idx == 8'd1) return blk_num;
    if (idx == 8'd2) return ~blk_num;
    if (idx < BLOCK_BYTES + 3) begin
      if (pos < loaded) d = blk_buf[pos[6:0]];
      else if (pos == loaded) d = PAD_BYTE;
      else d = 8'h00;
      chk = crc_on ? crc_byte(chk, d) : {8'h00, chk[7:0] + d};
      return d;
    end
    if (crc_on && idx == BLOCK_BYTES + 3) return chk[15:8];
    return chk[7:0];
  endfunction

  function automatic void line_event(input logic [7:0] lb);
    beat_live = 1'b1;
    case (ph)
      PH_SYNC_WAIT: begin
        if (lb == SYNC_CRC || lb == NAK_BYTE) begin
          crc_on = (lb == SYNC_CRC);
          open_block();
        end else if (lb == CAN_BYTE) begin
          timer = '0;
          ph    = PH_SYNC_CAN;
        end else begin
          sync_again();
        end
      end
      PH_SYNC_CAN: begin
        if (lb == CAN_BYTE) ph = PH_ACK_SEND;
        else sync_again();
      end
      PH_RESP_WAIT: begin
        if (lb == ACK_BYTE) begin
          blk_num = blk_num + 8'd1;
          acked   = acked + ACK_W'(BLOCK_BYTES);
          open_block();
        end else if (lb == CAN_BYTE) begin
          timer = '0;
          ph    = PH_RESP_CAN;
        end else begin
          resend_block();
        end
      end
      PH_RESP_CAN: begin
        if (lb == CAN_BYTE) ph = PH_ACK_SEND;
        else resend_block();
      end
      PH_EOT_WAIT: begin
        if (lb == ACK_BYTE) begin
          fin_status = ST_OK;
          ph         = PH_DONE;
        end else begin
          eot_again();
        end
      end
      default: beat_live = 1'b0;
    endcase
  endfunction

  // Advance the sender by one input beat and return the beat it must produce
  function automatic out_item_t sender_step(input in_item_t b);
    out_item_t    r;
    logic [15:0]  lim;
    logic         timed;
    r         = '0;
    lim       = '0;
    timed     = 1'b1;
    beat_live = 1'b0;
    case (b.op)
      OP_START: begin
        if (ph == PH_IDLE || ph == PH_DONE) begin
          beat_live  = 1'b1;
          total      = b.total_length;
          acked      = '0;
          blk_num    = 8'd1;
          tries      = '0;
          timer      = '0;
          crc_on     = 1'b0;
          fin_status = ST_OK;
          ph         = PH_SYNC_WAIT;
        end
      end
      OP_PAYLOAD: begin
        if (ph == PH_LOAD) begin
          beat_live = 1'b1;
          if (loaded < chunk_len()) begin
            blk_buf[loaded[6:0]] = b.payload_byte;
            loaded = loaded + 8'd1;
          end
          if (loaded >= chunk_len()) begin
            ph  = PH_SEND;
            idx = '0;
          end
        end
      end
      OP_LINE: line_event(b.line_byte);
      OP_READY: begin
        beat_live = 1'b1;
        case (ph)
          PH_SEND: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = frame_byte();
            idx        = idx + 8'd1;
            if (idx >= 8'(BLOCK_BYTES + 4) + {7'd0, crc_on}) begin
              timer = '0;
              ph    = PH_RESP_WAIT;
            end
          end
          PH_EOT_SEND: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = EOT_BYTE;
            timer      = '0;
            ph         = PH_EOT_WAIT;
          end
          PH_ACK_SEND: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = ACK_BYTE;
            fin_status = ST_CANCELLED;
            ph         = PH_DONE;
          end
          PH_CANCEL: begin
            r.tx_valid = 1'b1;
            r.tx_byte  = CAN_BYTE;
            if (cancels_left != 2'd0) cancels_left = cancels_left - 2'd1;
            if (cancels_left == 2'd0) ph = PH_DONE;
          end
          default: beat_live = 1'b0;
        endcase
      end
      OP_TICK: begin
        case (ph)
          PH_SYNC_WAIT, PH_EOT_WAIT:             lim = long_lim;
          PH_SYNC_CAN, PH_RESP_WAIT, PH_RESP_CAN: lim = short_lim;
          default:                               timed = 1'b0;
        endcase
        if (timed) begin
          beat_live = 1'b1;
          if (timer != 16'hFFFF) timer = timer + 16'd1;
          if (timer >= lim) begin
            if (ph == PH_SYNC_WAIT || ph == PH_SYNC_CAN) sync_again();
            else if (ph == PH_EOT_WAIT) eot_again();
            else resend_block();
          end
        end
      end
      default: ;
    endcase
    r.payload_request = (ph == PH_LOAD);
    r.payload_count   = (ph == PH_LOAD) ? chunk_len() : 8'd0;
    r.done_res        = (ph == PH_DONE);
    r.status          = (ph == PH_DONE) ? fin_status : ST_OK;
    r.sent_length     = acked;
    return r;
  endfunction

  // Mostly short transfers, some on block boundaries, a few huge ones
  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return '0;
    if (roll < 50) return LEN_W'($urandom_range(1, 40));
    if (roll < 70) return LEN_W'($urandom_range(120, 136));
    if (roll < 82) return LEN_W'($urandom_range(200, 300));
    if (roll < 94) return LEN_W'($urandom_range(41, 119));
    return LEN_W'($urandom());
  endfunction

  // Next beat: what a well-behaved peer would do now, with some noise
  function automatic in_item_t pick_beat();
    in_item_t b;
    int       roll;
    b.op           = 3'($urandom_range(0, 7));
    b.total_length = LEN_W'($urandom());
    b.payload_byte = 8'($urandom());
    b.line_byte    = 8'($urandom());
    if ($urandom_range(0, 99) < 4) return b;
    roll = $urandom_range(0, 99);
    case (ph)
      PH_IDLE, PH_DONE: begin
        b.op           = OP_START;
        b.total_length = pick_length();
      end
      PH_SYNC_WAIT: begin
        b.op = OP_LINE;
        if (roll < 40) b.line_byte = SYNC_CRC;
        else if (roll < 70) b.line_byte = NAK_BYTE;
        else if (roll < 76) b.line_byte = CAN_BYTE;
        else if (roll >= 86) b.op = OP_TICK;
      end
      PH_SYNC_CAN, PH_RESP_CAN: begin
        b.op = OP_LINE;
        if (roll < 65) b.line_byte = CAN_BYTE;
        else if (roll >= 80) b.op = OP_TICK;
      end
      PH_LOAD: b.op = OP_PAYLOAD;
      PH_RESP_WAIT: begin
        b.op = OP_LINE;
        if (roll < 60) b.line_byte = ACK_BYTE;
        else if (roll < 72) b.line_byte = NAK_BYTE;
        else if (roll < 76) b.line_byte = CAN_BYTE;
        else if (roll >= 80) b.op = OP_TICK;
      end
      PH_EOT_WAIT: begin
        b.op = OP_LINE;
        if (roll < 55) b.line_byte = ACK_BYTE;
        else if (roll < 75) b.line_byte = NAK_BYTE;
        else b.op = OP_TICK;
      end
      default: b.op = OP_READY;
    endcase
    return b;
  endfunction

  // Present one input beat (called at a falling edge, returns at one)
  task automatic send_beat(input in_item_t b, input logic fixed, input out_item_t fixed_res);
    out_item_t pred;
    while (quiet_left == 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = sender_step(b);
    awaited_results.push_back(fixed ? fixed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] which, input logic [CFG_DW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = which;
    cfg_data_i  = val;
    case (which)
      CFG_LONG_WAIT:  long_lim  = val;
      CFG_SHORT_WAIT: short_lim = val;
      CFG_SYNC_TRIES: sync_lim  = val[TRY_W-1:0];
      CFG_PKT_TRIES:  pkt_lim   = val[TRY_W-1:0];
      CFG_EOT_TRIES:  eot_lim   = val[TRY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [CFG_DW-1:0] lw, input logic [CFG_DW-1:0] sw,
                            input logic [CFG_DW-1:0] st, input logic [CFG_DW-1:0] pt,
                            input logic [CFG_DW-1:0] et);
    write_reg(CFG_LONG_WAIT, lw);
    write_reg(CFG_SHORT_WAIT, sw);
    write_reg(CFG_SYNC_TRIES, st);
    write_reg(CFG_PKT_TRIES, pt);
    write_reg(CFG_EOT_TRIES, et);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Stop feeding and let every awaited beat arrive (ends on a rising edge)
  task automatic drain();
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic report_fault(input string why, input out_item_t want, input out_item_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("%0t %s: want tx %0b/%02h req %0b/%0d done %0b st %0d sent %0d, got tx %0b/%02h req %0b/%0d done %0b st %0d sent %0d",
               $realtime, why,
               want.tx_valid, want.tx_byte, want.payload_request, want.payload_count,
               want.done_res, want.status, want.sent_length,
               got.tx_valid, got.tx_byte, got.payload_request, got.payload_count,
               got.done_res, got.status, got.sent_length);
  endtask

  // Result side: compare each accepted beat with the oldest awaited one
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        report_fault("unexpected beat", NO_RES, out_data_o);
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.tx_valid !== want.tx_valid || out_data_o.tx_byte !== want.tx_byte ||
            out_data_o.payload_request !== want.payload_request ||
            out_data_o.payload_count !== want.payload_count ||
            out_data_o.done_res !== want.done_res || out_data_o.status !== want.status ||
            out_data_o.sent_length !== want.sent_length)
          report_fault("mismatch", want, out_data_o);
      end
    end
  end

  // Occasional stretches with no idling on either side
  always @(posedge clk_i) begin
    if (quiet_left != 0) quiet_left <= quiet_left - 1;
    else if ($urandom_range(0, 99) < 3) quiet_left <= $urandom_range(10, 60);
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    out_stall_i <= (quiet_left == 0) && ($urandom_range(0, 99) < out_stall_pct);
  end

  // Watchdog: too long without any beat moving on either side
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < HANG_CYCLES) begin
      @(posedge clk_i);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        stuck = 0;
      else
        stuck++;
    end
    $display("xmodem_sender_core_test: errors");
    $finish;
  end

  initial begin : stimulus
    int          live_n;
    script_row_t row;
    in_item_t    b;
    model_reset();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int pass_no = 0; pass_no < PASSES; pass_no++) begin
      // sender/receiver idling: 32/78, then 78/32, then none
      case (pass_no / 2)
        0:       begin in_idle_pct = 32; out_stall_pct = 78; end
        1:       begin in_idle_pct = 78; out_stall_pct = 32; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase

      if (pass_no == 0) begin
        for (int i = 0; i < SCRIPT_LEN; i++) begin
          row            = script[i];
          b.op           = row.op;
          b.total_length = row.len;
          b.payload_byte = row.pb;
          b.line_byte    = row.lb;
          send_beat(b, row.fixed, row.res);
        end
      end else begin
        drain();
        case (pass_no)
          1: set_limits(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
          2: set_limits(CFG_DW'($urandom_range(1, 12)), CFG_DW'($urandom_range(1, 8)),
                        CFG_DW'($urandom_range(1, 6)), CFG_DW'($urandom_range(1, 6)),
                        CFG_DW'($urandom_range(1, 6)));
          3: set_limits(16'hFFFF, 16'hFFFF, 16'd31, 16'd31, 16'd31);
          4: set_limits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          default: set_limits(CFG_DW'($urandom_range(2, 40)), CFG_DW'($urandom_range(1, 25)),
                              CFG_DW'($urandom_range(2, 31)), CFG_DW'($urandom_range(2, 31)),
                              CFG_DW'($urandom_range(2, 31)));
        endcase
      end

      // random beats; ignored ones do not count
      live_n = 0;
      while (live_n < LIVE_PER_PASS) begin
        send_beat(pick_beat(), 1'b0, NO_RES);
        if (beat_live) live_n++;
      end
    end

    drain();
    if (fault_count == 0) begin
      $display("xmodem_sender_core_test: clean");
    end else begin
      $display("xmodem_sender_core_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/xms_pkg.sv
hw/rtl/xms_block_buf.sv
hw/rtl/xmodem_sender_core.sv
tb/sv/xmodem_sender_core_test.sv
